FILE: rtl/utf8_checking_json_string_escaper_assert.svh
// assertion macros shared by the checker
`ifndef UTF8_CHECKING_JSON_STRING_ESCAPER_ASSERT_SVH
`define UTF8_CHECKING_JSON_STRING_ESCAPER_ASSERT_SVH

// clocked assertion, switched off while reset is low
`define UCJSE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define UCJSE_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ucjse_pkg.sv
`default_nettype none

package ucjse_pkg;

	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_OPEN   = 2'd1;
	localparam logic [1:0] OP_CLOSE  = 2'd2;
	localparam logic [1:0] OP_IGNORE = 2'd3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	// 'a' minus ten, for lowercase hex digits
	localparam logic [7:0] CH_HEX_ALPHA_BASE = 8'h57;

	localparam logic [7:0] PRINT_MIN = 8'h20;
	localparam logic [7:0] PRINT_MAX = 8'h7E;

	localparam logic [7:0] LEAD_MIN  = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD_MAX  = 8'hF4;

	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;

	localparam logic [7:0] CONT_MIN    = 8'h80;
	localparam logic [7:0] CONT_MAX    = 8'hBF;
	localparam logic [7:0] CONT_E0_MIN = 8'hA0;
	localparam logic [7:0] CONT_ED_MAX = 8'h9F;
	localparam logic [7:0] CONT_F0_MIN = 8'h90;
	localparam logic [7:0] CONT_F4_MAX = 8'h8F;
	localparam logic [7:0] CONT_MASK   = 8'hC0;

	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	typedef enum logic [1:0] {
		TOK_RAW = 2'd0,
		TOK_ESC = 2'd1,
		TOK_HEX = 2'd2
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] val;
	} token_t;

	localparam int TOK_SLOTS = 4;
	localparam int SLOT_W    = $clog2(TOK_SLOTS);
	localparam int POS_W     = 3;

	typedef struct packed {
		token_t [TOK_SLOTS-1:0] tok;
		logic [SLOT_W-1:0]      last_slot;
	} cmd_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic       start;
		logic [2:0] seq_len;
		logic       emit;
		token_t     tok;
	} fresh_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'h0, d};
		end
		return CH_HEX_ALPHA_BASE + {4'h0, d};
	endfunction

	function automatic logic [POS_W-1:0] tok_last_pos(input tok_kind_t k);
		case (k)
			TOK_RAW: return POS_W'(0);
			TOK_ESC: return POS_W'(1);
			TOK_HEX: return POS_W'(5);
			default: return POS_W'(0);
		endcase
	endfunction

	function automatic logic [7:0] tok_char(input token_t t, input logic [POS_W-1:0] pos);
		case (t.kind)
			TOK_RAW: return t.val;
			TOK_ESC: return (pos == POS_W'(0)) ? CH_BSLASH : t.val;
			TOK_HEX: begin
				case (pos)
					POS_W'(0): return CH_BSLASH;
					POS_W'(1): return CH_U;
					POS_W'(2): return CH_ZERO;
					POS_W'(3): return CH_ZERO;
					POS_W'(4): return hex_char(t.val[7:4]);
					default:   return hex_char(t.val[3:0]);
				endcase
			end
			default: return t.val;
		endcase
	endfunction

	// a byte seen with no sequence pending
	function automatic fresh_t fresh_decode(input logic [7:0] c);
		fresh_t r;
		r.start   = 1'b0;
		r.seq_len = SEQ_NONE;
		r.emit    = 1'b1;
		r.tok     = '{kind: TOK_HEX, val: c};
		if (c inside {[LEAD_MIN:LEAD_MAX]}) begin
			r.start   = 1'b1;
			r.emit    = 1'b0;
			r.seq_len = (c <= LEAD2_MAX) ? SEQ_LEN2 : (c <= LEAD3_MAX) ? SEQ_LEN3 : SEQ_LEN4;
		end else begin
			case (c)
				CH_QUOTE:  r.tok = '{kind: TOK_ESC, val: CH_QUOTE};
				CH_BSLASH: r.tok = '{kind: TOK_ESC, val: CH_BSLASH};
				CH_LF:     r.tok = '{kind: TOK_ESC, val: CH_N};
				CH_CR:     r.tok = '{kind: TOK_ESC, val: CH_R};
				CH_TAB:    r.tok = '{kind: TOK_ESC, val: CH_T};
				default: begin
					if (c inside {[PRINT_MIN:PRINT_MAX]}) begin
						r.tok = '{kind: TOK_RAW, val: c};
					end
				end
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ucjse_in_if.sv
`default_nettype none

interface ucjse_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] byte_in;

	modport source (output valid, output op, output byte_in, input ready);
	modport sink (input valid, input op, input byte_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/ucjse_out_if.sv
`default_nettype none

interface ucjse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last_out;

	modport source (output valid, output char_out, output last_out, input ready);
	modport sink (input valid, input char_out, input last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/ucjse_cmd_fifo.sv
`default_nettype none

module ucjse_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  ucjse_pkg::cmd_t    push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output ucjse_pkg::cmd_t    head
);
	import ucjse_pkg::*;

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= FIFO_PTR_W'((32'(wr_ptr_q) + 1) % FIFO_DEPTH);
			end
			if (do_pop) begin
				rd_ptr_q <= FIFO_PTR_W'((32'(rd_ptr_q) + 1) % FIFO_DEPTH);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

`default_nettype wire

FILE: rtl/ucjse_front.sv
`default_nettype none

module ucjse_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ucjse_in_if.sink         byte_stream,
	input  wire logic        fifo_full,
	output logic             push,
	output ucjse_pkg::cmd_t  cmd
);
	import ucjse_pkg::*;

	logic [7:0] lead_q;
	logic [7:0] cont_q [2];
	logic [1:0] cnt_q;
	logic [2:0] seq_q;

	logic        accept;
	logic [7:0]  c;
	fresh_t      fr;
	logic        has_seq;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic        ok;
	logic        complete;
	logic [1:0]  pre_n;
	tok_kind_t   pre_kind;
	logic        extra_v;
	token_t      extra_tok;
	logic [2:0]  total;
	logic [2:0]  seq_d;
	logic [1:0]  cnt_d;
	logic        load_lead;
	logic        store_cont;
	logic [7:0]  held [TOK_SLOTS];

	assign byte_stream.ready = !fifo_full;
	assign accept = byte_stream.valid && !fifo_full;
	assign c      = byte_stream.byte_in;
	assign fr     = fresh_decode(c);

	assign has_seq  = (seq_q != SEQ_NONE);
	assign complete = (({1'b0, cnt_q} + 3'd2) >= seq_q);

	// first continuation byte range depends on the lead
	always_comb begin
		lo = CONT_MIN;
		hi = CONT_MAX;
		if (lead_q == LEAD_E0) lo = CONT_E0_MIN;
		if (lead_q == LEAD_ED) hi = CONT_ED_MAX;
		if (lead_q == LEAD_F0) lo = CONT_F0_MIN;
		if (lead_q == LEAD_F4) hi = CONT_F4_MAX;
		if (cnt_q == 2'd0) begin
			ok = (c >= lo) && (c <= hi);
		end else begin
			ok = ((c & CONT_MASK) == CONT_MIN);
		end
	end

	always_comb begin
		pre_n      = 2'd0;
		pre_kind   = TOK_HEX;
		extra_v    = 1'b0;
		extra_tok  = '{kind: TOK_RAW, val: CH_QUOTE};
		seq_d      = seq_q;
		cnt_d      = cnt_q;
		load_lead  = 1'b0;
		store_cont = 1'b0;
		case (byte_stream.op)
			OP_DATA: begin
				if (!has_seq || !ok) begin
					// flush whatever is held, then take the byte afresh
					pre_n     = has_seq ? 2'(cnt_q + 2'd1) : 2'd0;
					pre_kind  = TOK_HEX;
					extra_v   = fr.emit;
					extra_tok = fr.tok;
					seq_d     = fr.start ? fr.seq_len : SEQ_NONE;
					cnt_d     = 2'd0;
					load_lead = fr.start;
				end else if (complete) begin
					pre_n     = 2'(cnt_q + 2'd1);
					pre_kind  = TOK_RAW;
					extra_v   = 1'b1;
					extra_tok = '{kind: TOK_RAW, val: c};
					seq_d     = SEQ_NONE;
					cnt_d     = 2'd0;
				end else begin
					store_cont = 1'b1;
					cnt_d      = 2'(cnt_q + 2'd1);
				end
			end
			OP_OPEN: begin
				extra_v = 1'b1;
				seq_d   = SEQ_NONE;
				cnt_d   = 2'd0;
			end
			OP_CLOSE: begin
				pre_n    = has_seq ? 2'(cnt_q + 2'd1) : 2'd0;
				pre_kind = TOK_HEX;
				extra_v  = 1'b1;
				seq_d    = SEQ_NONE;
				cnt_d    = 2'd0;
			end
			default: begin
			end
		endcase
	end

	assign held[0] = lead_q;
	assign held[1] = cont_q[0];
	assign held[2] = cont_q[1];
	assign held[3] = c;

	assign total = {1'b0, pre_n} + {2'b00, extra_v};

	// held bytes first, then the token of the current byte or quote
	always_comb begin
		for (int i = 0; i < TOK_SLOTS; i++) begin
			if (SLOT_W'(i) < pre_n) begin
				cmd.tok[i] = '{kind: pre_kind, val: held[i]};
			end else begin
				cmd.tok[i] = extra_tok;
			end
		end
		cmd.last_slot = SLOT_W'(total - 3'd1);
	end

	assign push = accept && (total != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_NONE;
			cnt_q <= 2'd0;
		end else if (accept) begin
			seq_q <= seq_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load_lead) begin
			lead_q <= c;
		end
		if (accept && store_cont) begin
			cont_q[cnt_q[0]] <= c;
		end
	end
endmodule

`default_nettype wire

FILE: rtl/ucjse_back.sv
`default_nettype none

module ucjse_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  ucjse_pkg::cmd_t  head,
	output logic             pop,
	ucjse_out_if.source      char_stream
);
	import ucjse_pkg::*;

	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	token_t            cur;
	logic              tok_end;
	logic              cmd_end;
	logic              beat;

	assign cur     = head.tok[slot_q];
	assign tok_end = (pos_q == tok_last_pos(cur.kind));
	assign cmd_end = tok_end && (slot_q == head.last_slot);
	assign beat    = head_valid && char_stream.ready;
	assign pop     = beat && cmd_end;

	assign char_stream.valid    = head_valid;
	assign char_stream.char_out = tok_char(cur, pos_q);
	assign char_stream.last_out = cmd_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			pos_q  <= '0;
		end else if (beat) begin
			if (tok_end) begin
				pos_q  <= '0;
				slot_q <= cmd_end ? '0 : slot_q + SLOT_W'(1);
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end
endmodule

`default_nettype wire

FILE: rtl/utf8_checking_json_string_escaper.sv
// latency: with the queue empty, the first output beat of an item is offered the cycle after
//   it is accepted
// throughput: one item per cycle while the output is ready and each item yields at most one
//   character; an item yields up to 24 characters, one beat a cycle while the output is ready
// a 4-entry command queue lets input keep flowing while escapes drain
// reset: async active-low clears the pending utf-8 sequence and empties the queue
`default_nettype none

module utf8_checking_json_string_escaper (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ucjse_in_if.sink    byte_stream,
	ucjse_out_if.source char_stream
);
	import ucjse_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic full;
	logic pop;
	logic head_valid;

	ucjse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.fifo_full   (full),
		.push        (push),
		.cmd         (push_cmd)
	);

	ucjse_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ucjse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.char_stream (char_stream)
	);
endmodule

`default_nettype wire

FILE: rtl/ucjse_checker.sv
`default_nettype none
`include "utf8_checking_json_string_escaper_assert.svh"

module ucjse_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] char_out,
	input wire logic       last_out
);
	import ucjse_pkg::*;

	// stalled beat holds its payload
	`UCJSE_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_out), "output beat changed while stalled")

	// rest of an item is already queued once its first beat is out
	`UCJSE_ASSERT(a_item_unbroken, clk, arst_n, out_valid && out_ready && !last_out |=> out_valid, "gap inside the characters of one item")

	// a quote only ever ends an item
	`UCJSE_ASSERT(a_quote_last, clk, arst_n, out_valid && (char_out == CH_QUOTE) |-> last_out, "quote not on the last beat of its item")

	`UCJSE_ASSERT_NR(a_reset_quiet, clk, !arst_n |-> !out_valid && in_ready, "channels not idle in reset")
endmodule

bind utf8_checking_json_string_escaper ucjse_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_stream.valid),
	.in_ready  (byte_stream.ready),
	.out_valid (char_stream.valid),
	.out_ready (char_stream.ready),
	.char_out  (char_stream.char_out),
	.last_out  (char_stream.last_out)
);

`default_nettype wire
